### rtl/core/plid_pkg.sv
// Shared types and field widths for the positional list insert/delete core.
`timescale 1ns / 1ps

package plid_pkg;

  // Field widths of one transaction on each channel.
  localparam int unsigned OpW    = 2;
  localparam int unsigned PosW   = 16;
  localparam int unsigned DataW  = 32;
  localparam int unsigned StatW  = 3;
  localparam int unsigned CountW = 7;

  // Operation codes; the fourth code is a no-operation.
  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  // Result status codes.
  typedef enum logic [StatW-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_RANGE    = 3'd5
  } status_e;

endpackage

### rtl/core/positional_list_insert_delete_core.sv
// Top level of the positional list core: ordered list store, sequencer and result register.
`timescale 1ns / 1ps

//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+-------------------------------------------
//  input    | in_valid_i / in_stall_o    | op_i, position_i, value_i
//  output   | out_valid_o / out_stall_i  | status_o, read_data_o, entry_count_o
//
// An insert moves each entry from the end down to its slot up by one, a delete compares
// entries from the first until it finds its value and then moves those above it down,
// a read fetches one entry, and a rejected or no-operation transaction only returns a
// status. The input stalls until the previous result is passed to the output register.
// Reset empties the list at once; the memory contents need no clearing pass.
// A stalled result waits in the output register; the next result is held until it frees up.

module positional_list_insert_delete_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [plid_pkg::OpW-1:0]               op_i,
  input  logic [plid_pkg::PosW-1:0]              position_i,
  input  logic signed [plid_pkg::DataW-1:0]      value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [plid_pkg::StatW-1:0]             status_o,
  output logic signed [plid_pkg::DataW-1:0]      read_data_o,
  output logic [plid_pkg::CountW-1:0]            entry_count_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned LenW  = $clog2(CAPACITY + 1);

  // Sequencer states.
  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StInsMv  = 3'd1;
  localparam logic [2:0] StDelCmp = 3'd2;
  localparam logic [2:0] StDelMv  = 3'd3;
  localparam logic [2:0] StRdData = 3'd4;
  localparam logic [2:0] StDone   = 3'd5;

  logic [2:0]                          state_q, state_d;
  logic [LenW-1:0]                     len_q, len_d;
  logic [LenW-1:0]                     idx_q, idx_d;
  logic [LenW-1:0]                     slot_q, slot_d;
  logic signed [plid_pkg::DataW-1:0]   val_q, val_d;
  logic [plid_pkg::StatW-1:0]          res_status_q, res_status_d;
  logic signed [plid_pkg::DataW-1:0]   res_data_q, res_data_d;

  logic                                out_valid_q, out_valid_d;
  logic [plid_pkg::StatW-1:0]          out_status_q, out_status_d;
  logic signed [plid_pkg::DataW-1:0]   out_data_q, out_data_d;
  logic [plid_pkg::CountW-1:0]         out_count_q, out_count_d;

  // List store: one write and one registered read per cycle.
  logic signed [plid_pkg::DataW-1:0]   list_mem_q [CAPACITY];
  logic signed [plid_pkg::DataW-1:0]   mem_rd_q;
  logic                                mem_we;
  logic [AddrW-1:0]                    mem_waddr;
  logic [AddrW-1:0]                    mem_raddr;
  logic signed [plid_pkg::DataW-1:0]   mem_wdata;

  logic [plid_pkg::PosW-1:0]           pos_m1;
  logic                                out_free;

  assign pos_m1   = position_i - plid_pkg::PosW'(1);
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      list_mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rd_q <= list_mem_q[mem_raddr];
  end

  // The sequencer walks the list one entry per cycle. The read issued in one cycle
  // returns in the next, so a move writes the entry fetched by the previous cycle
  // while fetching the following one.
  always_comb begin
    state_d      = state_q;
    len_d        = len_q;
    idx_d        = idx_q;
    slot_d       = slot_q;
    val_d        = val_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    mem_we       = 1'b0;
    mem_waddr    = AddrW'(idx_q);
    mem_wdata    = mem_rd_q;
    mem_raddr    = '0;

    case (state_q)
      StIdle: begin
        // Start the first fetch while the transaction is being accepted.
        case (op_i)
          plid_pkg::OP_INSERT: mem_raddr = AddrW'(len_q - LenW'(1));
          plid_pkg::OP_READ:   mem_raddr = AddrW'(position_i);
          default:             mem_raddr = '0;
        endcase
        if (in_valid_i) begin
          val_d      = value_i;
          res_data_d = '0;
          state_d    = StDone;
          case (op_i)
            plid_pkg::OP_INSERT: begin
              if (position_i == '0) begin
                res_status_d = plid_pkg::ST_BADPOS;
              end else if (len_q == LenW'(CAPACITY)) begin
                res_status_d = plid_pkg::ST_FULL;
              end else begin
                // Positions past the end append.
                if (32'(pos_m1) > 32'(len_q)) begin
                  slot_d = len_q;
                end else begin
                  slot_d = LenW'(pos_m1);
                end
                idx_d   = len_q;
                state_d = StInsMv;
              end
            end
            plid_pkg::OP_DELETE: begin
              if (len_q == '0) begin
                res_status_d = plid_pkg::ST_EMPTY;
              end else begin
                idx_d   = '0;
                state_d = StDelCmp;
              end
            end
            plid_pkg::OP_READ: begin
              if (32'(position_i) < 32'(len_q)) begin
                state_d = StRdData;
              end else begin
                res_status_d = plid_pkg::ST_RANGE;
              end
            end
            default: begin
              res_status_d = plid_pkg::ST_OK;
            end
          endcase
        end
      end

      StInsMv: begin
        mem_we = 1'b1;
        if (idx_q > slot_q) begin
          // Move the entry below the destination up by one slot.
          mem_waddr = AddrW'(idx_q);
          mem_wdata = mem_rd_q;
          mem_raddr = AddrW'(idx_q - LenW'(2));
          idx_d     = idx_q - LenW'(1);
        end else begin
          mem_waddr    = AddrW'(slot_q);
          mem_wdata    = val_q;
          len_d        = len_q + LenW'(1);
          res_status_d = plid_pkg::ST_OK;
          state_d      = StDone;
        end
      end

      StDelCmp: begin
        mem_raddr = AddrW'(idx_q + LenW'(1));
        if (mem_rd_q == val_q) begin
          state_d = StDelMv;
        end else if (idx_q + LenW'(1) >= len_q) begin
          res_status_d = plid_pkg::ST_NOTFOUND;
          state_d      = StDone;
        end else begin
          idx_d = idx_q + LenW'(1);
        end
      end

      StDelMv: begin
        if (idx_q + LenW'(1) < len_q) begin
          // Close the gap: the entry above moves down one slot.
          mem_we    = 1'b1;
          mem_waddr = AddrW'(idx_q);
          mem_wdata = mem_rd_q;
          mem_raddr = AddrW'(idx_q + LenW'(2));
          idx_d     = idx_q + LenW'(1);
        end else begin
          len_d        = len_q - LenW'(1);
          res_status_d = plid_pkg::ST_OK;
          state_d      = StDone;
        end
      end

      StRdData: begin
        res_data_d   = mem_rd_q;
        res_status_d = plid_pkg::ST_OK;
        state_d      = StDone;
      end

      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output register: loaded from the held result once the previous one is taken.
  always_comb begin
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_count_d  = out_count_q;
    if (state_q == StDone && out_free) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_data_d   = res_data_q;
      out_count_d  = plid_pkg::CountW'(len_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    slot_q       <= slot_d;
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_count_q  <= out_count_d;
  end

  assign in_stall_o    = (state_q != StIdle);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign read_data_o   = out_data_q;
  assign entry_count_o = out_count_q;

`ifndef SYNTHESIS
  // The length never exceeds the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(len_q) <= 32'(CAPACITY))
    else $error("list length above capacity");

  // One transaction changes the length by at most one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q == $past(len_q)) || (len_q == $past(len_q) + LenW'(1)) ||
    (len_q == $past(len_q) - LenW'(1)))
    else $error("list length jumped");

  // The store is written only while an insert or delete is being worked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == StInsMv || state_q == StDelMv))
    else $error("store written outside a shift");

  // A new result appears only when leaving the result hold state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == StDone))
    else $error("result raised without a finished transaction");

  // The search never runs past the last entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDelCmp) |-> (idx_q < len_q))
    else $error("delete search beyond list length");
`endif

endmodule
